// ===== src/xbs_pkg.sv =====
// Shared types, protocol codes and the CRC-16 byte update for the block sender.
// No dependencies.
`timescale 1ns / 1ps

package xbs_pkg;

  localparam logic [7:0] SOH_BYTE = 8'h01;
  localparam logic [7:0] EOT_BYTE = 8'h04;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] NAK_BYTE = 8'h15;
  localparam logic [7:0] CAN_BYTE = 8'h18;
  localparam logic [7:0] CRC_REQ  = 8'h43;
  localparam logic [7:0] PAD_BYTE = 8'h1A;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [3:0]  TRIES_RESET = 4'd6;
  localparam logic [3:0]  TRIES_MAX = 4'd15;

  typedef enum logic [2:0] {
    PH_HANDSHAKE = 3'd0,
    PH_FILL      = 3'd1,
    PH_SEND      = 3'd2,
    PH_WAIT      = 3'd3,
    PH_EOT       = 3'd4,
    PH_DONE      = 3'd5,
    PH_ABORT     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    K_LINK    = 2'd0,
    K_PAYLOAD = 2'd1,
    K_END     = 2'd2,
    K_PULL    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       is_crc;
    logic       is_nak;
    logic       is_ack;
    logic       is_can;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/xmodem_block_sender.sv =====
// Block sender with CRC-16 or checksum framing: top level.
// Depends on xbs_pkg, xbs_front, xbs_queue, xbs_back.
//
// Usage:
//   Input channel (in_valid/in_ready, mode, data_byte) carries one transaction
//   per link byte received, payload byte, end of payload, or transmitter pull.
//   Output channel (out_valid/out_ready) returns exactly one result per input
//   transaction, in order: tx_valid/tx_byte/tx_last for pulls, accepted for
//   payload and end marks, and the phase and check mode after that transaction.
//   Configuration: cfg_wr_en writes cfg_wr_data into handshake_tries at once.
// Timing:
//   Each transaction passes through the decode register, queue and output register.
//   Throughput is one transaction per cycle while out_ready is high; the
//   block buffer is read one pull ahead, so back-to-back pulls do not stall.
// Reset (rst, synchronous): handshake phase, block number 1, handshake_tries 6,
//   queue and output register empty.
// Stall: while out_ready is low the result is held; the two-entry queue and
//   the decode register absorb up to three more transactions, then in_ready drops.
`timescale 1ns / 1ps

module xmodem_block_sender import xbs_pkg::*; #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       tx_last,
  output logic       accepted,
  output logic [2:0] phase,
  output logic       crc_mode
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  xbs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_cmd     (f_cmd)
  );

  xbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  xbs_back #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_cmd       (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .tx_last     (tx_last),
    .accepted    (accepted),
    .phase       (phase),
    .crc_mode    (crc_mode)
  );

endmodule

// ===== src/xbs_front.sv =====
// Input stage: registers each transaction and decodes mode and link byte codes.
// Depends on xbs_pkg.
`timescale 1ns / 1ps

module xbs_front import xbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [7:0] data_byte,
  output logic       f_valid,
  input  logic       f_ready,
  output cmd_t       f_cmd
);

  cmd_t cmd_dec;

  always_comb begin
    cmd_dec = '0;
    cmd_dec.data   = data_byte;
    cmd_dec.is_crc = (data_byte == CRC_REQ);
    cmd_dec.is_nak = (data_byte == NAK_BYTE);
    cmd_dec.is_ack = (data_byte == ACK_BYTE);
    cmd_dec.is_can = (data_byte == CAN_BYTE);
    unique case (mode)
      K_LINK:    cmd_dec.kind = K_LINK;
      K_PAYLOAD: cmd_dec.kind = K_PAYLOAD;
      K_END:     cmd_dec.kind = K_END;
      default:   cmd_dec.kind = K_PULL;
    endcase
  end

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_cmd <= cmd_dec;
    end
  end

endmodule

// ===== src/xbs_queue.sv =====
// Two-entry command queue between the decode stage and the protocol engine.
// Depends on xbs_pkg.
`timescale 1ns / 1ps

module xbs_queue import xbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/xbs_back.sv =====
// Protocol engine: handshake, block buffer, packet framing, check, reply handling.
// Depends on xbs_pkg; fed by xbs_queue, drives the output register.
`timescale 1ns / 1ps

module xbs_back import xbs_pkg::*; #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic       q_valid,
  output logic       q_ready,
  input  cmd_t       q_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       tx_valid,
  output logic [7:0] tx_byte,
  output logic       tx_last,
  output logic       accepted,
  output logic [2:0] phase,
  output logic       crc_mode
);

  localparam int AW  = $clog2(BLOCK_BYTES);
  localparam int FCW = $clog2(BLOCK_BYTES + 1);
  localparam int SIW = $clog2(BLOCK_BYTES + 6);
  localparam logic [FCW-1:0] FILL_FULL = FCW'(BLOCK_BYTES);
  localparam logic [SIW-1:0] DATA_END  = SIW'(BLOCK_BYTES + 3);
  localparam logic [SIW-1:0] LAST_SUM  = SIW'(BLOCK_BYTES + 3);
  localparam logic [SIW-1:0] LAST_CRC  = SIW'(BLOCK_BYTES + 4);

  logic [7:0]     mem [BLOCK_BYTES];
  logic [7:0]     rd_data;
  logic [SIW-1:0] rd_idx;

  phase_t         ph, ph_next;
  logic [FCW-1:0] fill_count, fill_count_next;
  logic [SIW-1:0] send_index, send_index_next;
  logic [7:0]     block_number, block_number_next;
  logic           crc_sel, crc_sel_next;
  logic [3:0]     tries_seen, tries_seen_next;
  logic [15:0]    check, check_next;
  logic           end_seen, end_seen_next;
  logic [3:0]     hs_tries;

  logic           take;
  logic           wr_en;
  logic [SIW-1:0] d_idx;
  logic [7:0]     data_b;
  logic [3:0]     tries_inc;
  logic           r_txv, r_txl, r_acc;
  logic [7:0]     r_txb;

  phase_t         o_phase;
  logic           o_txv, o_txl, o_acc, o_crc;
  logic [7:0]     o_txb;

  assign take    = q_valid && (!out_valid || out_ready);
  assign q_ready = !out_valid || out_ready;

  assign d_idx     = send_index - SIW'(3);
  assign data_b    = (d_idx < SIW'(fill_count)) ? rd_data : PAD_BYTE;
  assign tries_inc = (tries_seen == TRIES_MAX) ? tries_seen : tries_seen + 4'd1;
  assign rd_idx    = send_index_next - SIW'(3);

  always_comb begin
    ph_next           = ph;
    fill_count_next   = fill_count;
    send_index_next   = send_index;
    block_number_next = block_number;
    crc_sel_next      = crc_sel;
    tries_seen_next   = tries_seen;
    check_next        = check;
    end_seen_next     = end_seen;
    wr_en             = 1'b0;
    r_txv             = 1'b0;
    r_txb             = 8'h00;
    r_txl             = 1'b0;
    r_acc             = 1'b0;
    if (take) begin
      unique case (q_cmd.kind)
        K_LINK: begin
          if (ph == PH_HANDSHAKE) begin
            if (q_cmd.is_crc || q_cmd.is_nak) begin
              crc_sel_next    = q_cmd.is_crc;
              ph_next         = PH_FILL;
              fill_count_next = '0;
            end else begin
              tries_seen_next = tries_inc;
              if (tries_inc >= hs_tries) begin
                ph_next = PH_ABORT;
              end
            end
          end else if (ph == PH_WAIT) begin
            if (q_cmd.is_ack) begin
              block_number_next = block_number + 8'd1;
              fill_count_next   = '0;
              ph_next           = end_seen ? PH_EOT : PH_FILL;
            end else if (q_cmd.is_nak) begin
              ph_next         = PH_SEND;
              send_index_next = '0;
              check_next      = '0;
            end else if (q_cmd.is_can) begin
              ph_next = PH_ABORT;
            end
          end else if (ph == PH_EOT) begin
            if (q_cmd.is_ack) begin
              ph_next = PH_DONE;
            end
          end
        end
        K_PAYLOAD: begin
          if (ph == PH_FILL && fill_count < FILL_FULL) begin
            wr_en           = 1'b1;
            fill_count_next = fill_count + FCW'(1);
            r_acc           = 1'b1;
            if (fill_count_next == FILL_FULL) begin
              ph_next         = PH_SEND;
              send_index_next = '0;
              check_next      = '0;
            end
          end
        end
        K_END: begin
          if (ph == PH_FILL) begin
            r_acc         = 1'b1;
            end_seen_next = 1'b1;
            if (fill_count == '0) begin
              ph_next = PH_EOT;
            end else begin
              ph_next         = PH_SEND;
              send_index_next = '0;
              check_next      = '0;
            end
          end
        end
        default: begin
          if (ph == PH_SEND) begin
            r_txv = 1'b1;
            if (send_index == SIW'(0)) begin
              check_next = '0;
              r_txb      = SOH_BYTE;
            end else if (send_index == SIW'(1)) begin
              r_txb = block_number;
            end else if (send_index == SIW'(2)) begin
              r_txb = ~block_number;
            end else if (send_index < DATA_END) begin
              r_txb = data_b;
              if (crc_sel) begin
                check_next = crc16_byte(check, data_b);
              end else begin
                check_next = {8'h00, check[7:0] + data_b};
              end
            end else if (crc_sel && send_index == DATA_END) begin
              r_txb = check[15:8];
            end else begin
              r_txb = check[7:0];
            end
            send_index_next = send_index + SIW'(1);
            if (send_index == (crc_sel ? LAST_CRC : LAST_SUM)) begin
              r_txl   = 1'b1;
              ph_next = PH_WAIT;
            end
          end else if (ph == PH_EOT) begin
            r_txv = 1'b1;
            r_txb = EOT_BYTE;
            r_txl = 1'b1;
          end
        end
      endcase
    end
  end

  // Read address tracks the next send index so data is ready on the next pull.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_count[AW-1:0]] <= q_cmd.data;
    end
    rd_data <= mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph           <= PH_HANDSHAKE;
      fill_count   <= '0;
      send_index   <= '0;
      block_number <= 8'd1;
      crc_sel      <= 1'b0;
      tries_seen   <= 4'd0;
      check        <= 16'h0000;
      end_seen     <= 1'b0;
      hs_tries     <= TRIES_RESET;
      out_valid    <= 1'b0;
    end else begin
      ph           <= ph_next;
      fill_count   <= fill_count_next;
      send_index   <= send_index_next;
      block_number <= block_number_next;
      crc_sel      <= crc_sel_next;
      tries_seen   <= tries_seen_next;
      check        <= check_next;
      end_seen     <= end_seen_next;
      if (cfg_wr_en) begin
        hs_tries <= cfg_wr_data;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      o_txv   <= r_txv;
      o_txb   <= r_txb;
      o_txl   <= r_txl;
      o_acc   <= r_acc;
      o_phase <= ph_next;
      o_crc   <= crc_sel_next;
    end
  end

  assign tx_valid = o_txv;
  assign tx_byte  = o_txb;
  assign tx_last  = o_txl;
  assign accepted = o_acc;
  assign phase    = o_phase;
  assign crc_mode = o_crc;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_FULL)
    else $error("fill count past block size");

  a_done_final: assert property (@(posedge clk) disable iff (rst)
    ph == PH_DONE |=> ph == PH_DONE)
    else $error("left done phase");

  a_abort_final: assert property (@(posedge clk) disable iff (rst)
    ph == PH_ABORT |=> ph == PH_ABORT)
    else $error("left aborted phase");

  a_send_bound: assert property (@(posedge clk) disable iff (rst)
    ph == PH_SEND |-> send_index <= LAST_CRC)
    else $error("send index past packet end");

  a_last_to_wait: assert property (@(posedge clk) disable iff (rst)
    take && r_txl && ph == PH_SEND |=> ph == PH_WAIT)
    else $error("packet end without reply wait");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for xmodem_block_sender: a directed table, then protocol-aware random traffic.
// Every output transaction is checked against an in-bench model of the sender.
// Depends on xbs_pkg and the xmodem_block_sender RTL.
`timescale 1ns / 1ps

module tb;
  import xbs_pkg::*;

  localparam int BLOCK_BYTES = 128;
  localparam int LATENCY = 2;
  localparam int N_ITEMS = 1750;
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic       vld;
    logic [7:0] byt;
    logic       lst;
    logic       acc;
    phase_t     ph;
    logic       crc;
  } tx_result_t;

  typedef struct {
    kind_t      k;
    logic [7:0] d;
    bit         typed;
    tx_result_t want;
  } stim_row_t;

  localparam tx_result_t HS_QUIET = '{1'b0, 8'h00, 1'b0, 1'b0, PH_HANDSHAKE, 1'b0};

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_wr_en;
  logic [3:0] cfg_wr_data;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] mode;
  logic [7:0] data_byte;
  logic       out_valid;
  logic       out_ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_last;
  logic       accepted;
  logic [2:0] phase;
  logic       crc_mode;

  // sender model state
  logic [7:0]  blk_buf [BLOCK_BYTES];
  int unsigned fill_n;
  int unsigned send_pos;
  logic [7:0]  blk_no;
  logic        crc_on;
  phase_t      proto_ph;
  logic [3:0]  hs_other;
  logic [3:0]  hs_limit;
  logic [15:0] run_chk;
  logic        eof_seen;

  tx_result_t sender_out_q[$];
  int n_bad = 0;
  int work_n = 0;
  int n_cfg = 0;
  int tx_calm = 0;
  int rx_calm = 0;

  xmodem_block_sender #(.BLOCK_BYTES(BLOCK_BYTES)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tx_valid(tx_valid),
    .tx_byte(tx_byte),
    .tx_last(tx_last),
    .accepted(accepted),
    .phase(phase),
    .crc_mode(crc_mode)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // CRC-16, poly 0x1021, one data bit at a time, MSB first
  function automatic logic [15:0] crc_ccitt_shift(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = acc[15] ^ b[k];
      acc = {acc[14:0], 1'b0};
      if (fb) acc = acc ^ CRC_POLY;
    end
    return acc;
  endfunction

  function automatic tx_result_t sender_step(input kind_t k, input logic [7:0] d);
    tx_result_t r;
    logic [7:0] b;
    int unsigned pkt_len;
    r = '0;
    pkt_len = 3 + BLOCK_BYTES + (crc_on ? 2 : 1);
    case (k)
      K_LINK: begin
        if (proto_ph == PH_HANDSHAKE) begin
          if (d == CRC_REQ || d == NAK_BYTE) begin
            crc_on = (d == CRC_REQ);
            proto_ph = PH_FILL;
            fill_n = 0;
          end else begin
            if (hs_other != TRIES_MAX) hs_other++;
            if (hs_other >= hs_limit) proto_ph = PH_ABORT;
          end
        end else if (proto_ph == PH_WAIT) begin
          if (d == ACK_BYTE) begin
            blk_no++;
            fill_n = 0;
            proto_ph = eof_seen ? PH_EOT : PH_FILL;
          end else if (d == NAK_BYTE) begin
            proto_ph = PH_SEND;
            send_pos = 0;
            run_chk = '0;
          end else if (d == CAN_BYTE) begin
            proto_ph = PH_ABORT;
          end
        end else if (proto_ph == PH_EOT && d == ACK_BYTE) begin
          proto_ph = PH_DONE;
        end
      end
      K_PAYLOAD: begin
        if (proto_ph == PH_FILL) begin
          blk_buf[fill_n] = d;
          fill_n++;
          r.acc = 1'b1;
          if (fill_n == BLOCK_BYTES) begin
            proto_ph = PH_SEND;
            send_pos = 0;
            run_chk = '0;
          end
        end
      end
      K_END: begin
        if (proto_ph == PH_FILL) begin
          r.acc = 1'b1;
          eof_seen = 1'b1;
          if (fill_n == 0) begin
            proto_ph = PH_EOT;
          end else begin
            proto_ph = PH_SEND;
            send_pos = 0;
            run_chk = '0;
          end
        end
      end
      default: begin
        if (proto_ph == PH_SEND) begin
          r.vld = 1'b1;
          if (send_pos == 0) begin
            run_chk = '0;
            r.byt = SOH_BYTE;
          end else if (send_pos == 1) begin
            r.byt = blk_no;
          end else if (send_pos == 2) begin
            r.byt = 8'hFF - blk_no;
          end else if (send_pos < 3 + BLOCK_BYTES) begin
            b = (send_pos - 3 < fill_n) ? blk_buf[send_pos - 3] : PAD_BYTE;
            if (crc_on) run_chk = crc_ccitt_shift(run_chk, b);
            else run_chk = {8'h00, run_chk[7:0] + b};
            r.byt = b;
          end else if (crc_on && send_pos == 3 + BLOCK_BYTES) begin
            r.byt = run_chk[15:8];
          end else begin
            r.byt = run_chk[7:0];
          end
          send_pos++;
          if (send_pos >= pkt_len) begin
            r.lst = 1'b1;
            proto_ph = PH_WAIT;
          end
        end else if (proto_ph == PH_EOT) begin
          r.vld = 1'b1;
          r.byt = EOT_BYTE;
          r.lst = 1'b1;
        end
      end
    endcase
    r.ph = proto_ph;
    r.crc = crc_on;
    return r;
  endfunction

  // idle cycles before the next transaction, with runs of back-to-back traffic
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  task automatic offer(input kind_t k, input logic [7:0] d, input bit typed = 1'b0,
                       input tx_result_t want = '0);
    int gap;
    tx_result_t res;
    gap = pick_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= k;
    data_byte <= d;
    do @(posedge clk); while (in_ready !== 1'b1);
    res = sender_step(k, d);
    sender_out_q.push_back(typed ? want : res);
  endtask

  task automatic gen_one();
    int r;
    logic [7:0] b;
    logic [3:0] v;
    r = $urandom_range(0, 15);
    b = 8'($urandom_range(0, 255));
    case (proto_ph)
      PH_FILL: begin
        if (r == 0) begin
          offer(($urandom_range(0, 1) != 0) ? K_LINK : K_PULL, b);
        end else begin
          if (r == 1) b = 8'h00;
          else if (r == 2) b = 8'hFF;
          else if (r == 3) b = PAD_BYTE;
          offer(K_PAYLOAD, b);
          work_n++;
        end
      end
      PH_SEND: begin
        if (r == 0) begin
          offer(kind_t'($urandom_range(0, 2)), b);
        end else begin
          offer(K_PULL, b);
          work_n++;
        end
      end
      PH_WAIT: begin
        if (r == 0) begin
          if (b == ACK_BYTE || b == NAK_BYTE || b == CAN_BYTE) b = CRC_REQ;
          offer(K_LINK, b);
        end else if (r == 1) begin
          offer(kind_t'($urandom_range(1, 3)), b);
        end else if (r < 5) begin
          offer(K_LINK, NAK_BYTE);
          work_n++;
        end else begin
          offer(K_LINK, ACK_BYTE);
          work_n++;
          // block boundary: let the sender go quiet, then rewrite the register
          if (n_cfg < 2 || $urandom_range(0, 2) == 0) begin
            if (n_cfg == 0) v = 4'd0;
            else if (n_cfg == 1) v = 4'd15;
            else v = 4'($urandom_range(0, 15));
            in_valid <= 1'b0;
            while (sender_out_q.size() != 0) @(posedge clk);
            repeat (LATENCY + 2) @(posedge clk);
            cfg_wr_en <= 1'b1;
            cfg_wr_data <= v;
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            hs_limit = v;
            n_cfg++;
          end
        end
      end
      default: offer(K_PULL, b);
    endcase
  endtask

  initial begin : stim
    stim_row_t dir_rows[$];
    logic [7:0] hs_byte;
    int ending;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = K_LINK;
    data_byte = 8'h00;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    fill_n = 0;
    send_pos = 0;
    blk_no = 8'd1;
    crc_on = 1'b0;
    proto_ph = PH_HANDSHAKE;
    hs_other = '0;
    hs_limit = TRIES_RESET;
    run_chk = '0;
    eof_seen = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    hs_byte = ($urandom_range(0, 1) != 0) ? CRC_REQ : NAK_BYTE;
    // handshake phase: nothing to send, payload refused, other bytes counted
    dir_rows.push_back('{K_PULL, 8'h00, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_PULL, 8'hFF, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_PAYLOAD, 8'hFF, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_PAYLOAD, 8'h00, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_END, 8'h5A, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_LINK, 8'h00, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_LINK, 8'hFF, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_LINK, ACK_BYTE, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_LINK, CAN_BYTE, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_LINK, 8'h42, 1'b1, HS_QUIET});
    dir_rows.push_back('{K_LINK, hs_byte, 1'b0, '0});
    // filling: link bytes and pulls ignored, payload bytes accepted
    dir_rows.push_back('{K_LINK, CAN_BYTE, 1'b0, '0});
    dir_rows.push_back('{K_PULL, 8'h00, 1'b0, '0});
    dir_rows.push_back('{K_PAYLOAD, 8'h00, 1'b0, '0});
    dir_rows.push_back('{K_PAYLOAD, 8'hFF, 1'b0, '0});
    dir_rows.push_back('{K_PAYLOAD, PAD_BYTE, 1'b0, '0});
    dir_rows.push_back('{K_PAYLOAD, 8'h55, 1'b0, '0});
    dir_rows.push_back('{K_PAYLOAD, 8'hAA, 1'b0, '0});
    foreach (dir_rows[i]) offer(dir_rows[i].k, dir_rows[i].d, dir_rows[i].typed, dir_rows[i].want);

    while (work_n < N_ITEMS) gen_one();
    while (proto_ph != PH_WAIT) gen_one();

    ending = $urandom_range(0, 3);
    if (ending == 0) begin
      offer(K_LINK, CAN_BYTE);
    end else begin
      offer(K_LINK, ACK_BYTE);
      if (ending == 1) begin
        // short final block, then EOT after its ACK
        repeat ($urandom_range(1, 40)) offer(K_PAYLOAD, 8'($urandom_range(0, 255)));
        offer(K_END, 8'hFF);
        while (proto_ph == PH_SEND) offer(K_PULL, 8'h00);
        offer(K_LINK, ACK_BYTE);
      end else begin
        // end mark on an empty block goes straight to EOT
        offer(K_END, 8'($urandom_range(0, 255)));
      end
      repeat ($urandom_range(2, 5)) begin
        offer(K_PULL, 8'h00);
        offer(K_LINK, NAK_BYTE);
      end
      offer(K_LINK, ACK_BYTE);
    end
    // terminal phase: everything ignored
    repeat (12) offer(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    in_valid <= 1'b0;

    while (sender_out_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (n_bad == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : rx_side
    tx_result_t want;
    int seen;
    seen = 0;
    out_ready = 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    forever begin
      if (seen == 300 || seen == 1100) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (pick_wait(rx_calm) > 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      seen++;
      if (sender_out_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("output %0d with no transaction pending: v%0b %02h l%0b a%0b ph%0d c%0b",
                   seen, tx_valid, tx_byte, tx_last, accepted, phase, crc_mode);
      end else begin
        want = sender_out_q.pop_front();
        if (tx_valid !== want.vld || tx_byte !== want.byt || tx_last !== want.lst ||
            accepted !== want.acc || phase !== want.ph || crc_mode !== want.crc) begin
          n_bad++;
          if (n_bad <= 10) begin
            $write("output %0d mismatch: exp v%0b %02h l%0b a%0b ph%0d c%0b,", seen,
                   want.vld, want.byt, want.lst, want.acc, want.ph, want.crc);
            $display(" got v%0b %02h l%0b a%0b ph%0d c%0b",
                     tx_valid, tx_byte, tx_last, accepted, phase, crc_mode);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
